[src/cefq_pkg.sv]
// Shared types, codes and the admission table for the charger event filter
// and its coalescing queue. Used by every module under src; depends on nothing.
`default_nettype none

package cefq_pkg;

   // Default number of ring slots; the ring holds at most one less.
   localparam int unsigned QUEUE_DEPTH = 16;

   // Event codes.
   localparam logic [2:0] EV_START_SINK     = 3'd0;
   localparam logic [2:0] EV_STOP_SINK      = 3'd1;
   localparam logic [2:0] EV_START_SOURCE   = 3'd2;
   localparam logic [2:0] EV_STOP_SOURCE    = 3'd3;
   localparam logic [2:0] EV_START_WIRELESS = 3'd4;
   localparam logic [2:0] EV_STOP_WIRELESS  = 3'd5;
   localparam logic [2:0] EV_NONE           = 3'd6;

   // Request actions.
   localparam logic [1:0] ACT_POST   = 2'd0;
   localparam logic [1:0] ACT_POP    = 2'd1;
   localparam logic [1:0] ACT_DRAIN  = 2'd2;

   // Result status codes.
   localparam logic [2:0] ST_QUEUED   = 3'd0;
   localparam logic [2:0] ST_FULL     = 3'd1;
   localparam logic [2:0] ST_REJECTED = 3'd2;
   localparam logic [2:0] ST_IGNORED  = 3'd3;
   localparam logic [2:0] ST_POPPED   = 3'd4;
   localparam logic [2:0] ST_EMPTY    = 3'd5;
   localparam logic [2:0] ST_CLEARED  = 3'd6;

   // Configuration register indexes.
   localparam logic REG_BYPASS   = 1'b0;
   localparam logic REG_HANDLERS = 1'b1;

   // Admission rows, one per new event; bit j is set when the new event may
   // follow present event j.
   localparam logic [5:0] ADMIT_ROWS [0:5] = '{
      6'b111010,
      6'b000001,
      6'b111010,
      6'b110100,
      6'b101110,
      6'b011100
   };

   // Result fields that are known when the item is accepted. The popped entry
   // itself comes later, from the ring memory's registered read.
   typedef struct packed {
      logic [2:0] status;
      logic       pop_ok;
      logic [2:0] present;
      logic [2:0] prior;
      logic       online;
      logic       wireless_to_wired;
      logic [3:0] count;
   } rsp_info_type;

   function automatic logic event_admitted(input logic [2:0] code,
                                           input logic [2:0] present);
      logic ok;
      ok = 1'b0;
      if (code < EV_NONE) begin
         if (present >= EV_NONE) begin
            ok = 1'b1;
         end else begin
            ok = ADMIT_ROWS[code][present];
         end
      end
      return ok;
   endfunction

   function automatic logic is_stop_event(input logic [2:0] code);
      return (code == EV_STOP_SINK) || (code == EV_STOP_SOURCE) ||
             (code == EV_STOP_WIRELESS);
   endfunction

endpackage

`default_nettype wire

[src/cefq_ring.sv]
// Event ring storage: a single-port-write, registered-read memory with a
// written flag per slot so that unwritten slots read as zero. Uses cefq_pkg.
`default_nettype none

module cefq_ring #(
   parameter int unsigned QUEUE_DEPTH = cefq_pkg::QUEUE_DEPTH,
   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [PTR_W-1:0] wr_addr,
   input  wire logic [2:0]       wr_data,
   input  wire logic             rd_en,
   input  wire logic [PTR_W-1:0] rd_addr,
   output      logic [2:0]       rd_event
);

   logic [2:0]             mem [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] written_ff;
   logic [2:0]             rd_data_ff;
   logic                   rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
         rd_hit_ff  <= 1'b0;
      end else begin
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= written_ff[rd_addr];
         end
      end
   end

   assign rd_event = rd_hit_ff ? rd_data_ff : 3'd0;

endmodule

`default_nettype wire

[src/cefq_ctrl.sv]
// Admission filter, event state and ring pointer control, including the
// merge mode that coalesces events into one slot. Uses cefq_pkg.
`default_nettype none

module cefq_ctrl #(
   parameter int unsigned QUEUE_DEPTH = cefq_pkg::QUEUE_DEPTH,
   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [1:0]            action,
   input  wire logic [2:0]            event_code,
   input  wire logic                  bypass,
   input  wire logic                  handlers,
   output      logic                  wr_en,
   output      logic [PTR_W-1:0]      wr_addr,
   output      logic                  rd_en,
   output      logic [PTR_W-1:0]      rd_addr,
   output      cefq_pkg::rsp_info_type info
);

   logic [2:0]       present_ff, present_in;
   logic [2:0]       prior_ff, prior_in;
   logic             online_ff, online_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic             merge_ff, merge_in;
   logic [PTR_W-1:0] slot_ff, slot_in;
   logic [PTR_W-1:0] wp_step;
   logic [PTR_W:0]   diff;
   logic             put_wr;
   logic [PTR_W-1:0] put_addr;

   function automatic logic [PTR_W-1:0] wrap_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      present_in  = present_ff;
      prior_in    = prior_ff;
      online_in   = online_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      merge_in    = merge_ff;
      slot_in     = slot_ff;
      wp_step     = wp_ff;
      put_wr      = 1'b0;
      put_addr    = wp_ff;
      info.status = cefq_pkg::ST_IGNORED;
      info.pop_ok = 1'b0;

      case (action)
         cefq_pkg::ACT_POST: begin
            if (bypass || !handlers) begin
               info.status = cefq_pkg::ST_IGNORED;
            end else if (!cefq_pkg::event_admitted(event_code, present_ff)) begin
               info.status = cefq_pkg::ST_REJECTED;
            end else begin
               online_in  = (event_code == cefq_pkg::EV_START_SINK) ||
                            (event_code == cefq_pkg::EV_START_WIRELESS);
               prior_in   = present_ff;
               present_in = event_code;
               if (wrap_next(wp_ff) == rp_ff) begin
                  info.status = cefq_pkg::ST_FULL;
               end else begin
                  info.status = cefq_pkg::ST_QUEUED;
                  put_wr      = 1'b1;
                  if (merge_ff) begin
                     // Skip over the merge slot's own position, and when that
                     // leaves the ring empty restart in the next slot.
                     wp_step = (slot_ff == wp_ff) ? wrap_next(wp_ff) : wp_ff;
                     if (wp_step == rp_ff) begin
                        slot_in  = wrap_next(slot_ff);
                        wp_in    = wrap_next(wp_step);
                        merge_in = 1'b0;
                     end else begin
                        wp_in = wp_step;
                     end
                     put_addr = slot_in;
                  end else begin
                     put_addr = wp_ff;
                     wp_in    = wrap_next(wp_ff);
                  end
               end
               if (cefq_pkg::is_stop_event(event_code) && !merge_in) begin
                  merge_in = 1'b1;
                  slot_in  = wp_in;
               end
            end
         end
         cefq_pkg::ACT_POP: begin
            if (wp_ff == rp_ff) begin
               info.status = cefq_pkg::ST_EMPTY;
            end else begin
               info.status = cefq_pkg::ST_POPPED;
               info.pop_ok = 1'b1;
               rp_in       = wrap_next(rp_ff);
            end
         end
         cefq_pkg::ACT_DRAIN: begin
            merge_in    = 1'b0;
            slot_in     = '0;
            info.status = cefq_pkg::ST_CLEARED;
         end
         default: begin
            info.status = cefq_pkg::ST_IGNORED;
         end
      endcase

      if (wp_in >= rp_in) begin
         diff = {1'b0, wp_in} - {1'b0, rp_in};
      end else begin
         diff = {1'b0, wp_in} + (PTR_W + 1)'(QUEUE_DEPTH) - {1'b0, rp_in};
      end

      info.present           = present_in;
      info.prior             = prior_in;
      info.online            = online_in;
      info.wireless_to_wired = (prior_in == cefq_pkg::EV_START_WIRELESS) &&
                               (present_in == cefq_pkg::EV_START_SINK);
      info.count             = 4'(diff);
   end

   assign wr_en   = accept && put_wr;
   assign wr_addr = put_addr;
   assign rd_en   = accept && info.pop_ok;
   assign rd_addr = rp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         present_ff <= cefq_pkg::EV_NONE;
         prior_ff   <= cefq_pkg::EV_NONE;
         online_ff  <= 1'b0;
         wp_ff      <= '0;
         rp_ff      <= '0;
         merge_ff   <= 1'b0;
         slot_ff    <= '0;
      end else if (accept) begin
         present_ff <= present_in;
         prior_ff   <= prior_in;
         online_ff  <= online_in;
         wp_ff      <= wp_in;
         rp_ff      <= rp_in;
         merge_ff   <= merge_in;
         slot_ff    <= slot_in;
      end
   end

endmodule

`default_nettype wire

[src/charger_event_filter_coalescing_queue.sv]
// Charger event filter with a coalescing event queue. Posts are checked
// against an admission table and the present event, then written into a ring
// of QUEUE_DEPTH slots (at most QUEUE_DEPTH-1 held); after a stop event later
// posts coalesce into one slot until a drain request or the ring drains. One
// request is taken per cycle unless req_stall is raised; results go through
// the pending stage, which waits for the registered ring read used by pops, and
// then the output register. Per-slot written flags mean no clearing pass after
// reset. Depends on cefq_pkg, cefq_ctrl and cefq_ring.
`default_nettype none

module charger_event_filter_coalescing_queue #(
   parameter int unsigned QUEUE_DEPTH = cefq_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [2:0]  req_event_code,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      logic [2:0]  rsp_status,
   output      logic [2:0]  rsp_popped_event,
   output      logic [2:0]  rsp_present_event,
   output      logic [2:0]  rsp_prior_event,
   output      logic        rsp_charger_online,
   output      logic        rsp_wireless_to_wired,
   output      logic [3:0]  rsp_queue_count,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output      logic [31:0] csr_prdata,
   output      logic        csr_pready
);

   localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

   logic                   bypass_ff;
   logic                   handlers_ff;
   logic                   accept;
   logic                   out_free;
   logic                   wr_en;
   logic [PTR_W-1:0]       wr_addr;
   logic                   rd_en;
   logic [PTR_W-1:0]       rd_addr;
   logic [2:0]             rd_event;
   cefq_pkg::rsp_info_type info;
   cefq_pkg::rsp_info_type pend_info_ff;
   logic                   pend_valid_ff;
   logic                   rsp_valid_ff;
   logic [2:0]             rsp_status_ff;
   logic [2:0]             rsp_popped_event_ff;
   logic [2:0]             rsp_present_event_ff;
   logic [2:0]             rsp_prior_event_ff;
   logic                   rsp_charger_online_ff;
   logic                   rsp_wireless_to_wired_ff;
   logic [3:0]             rsp_queue_count_ff;
   logic                   csr_index;

   // Configuration registers.
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         bypass_ff   <= 1'b0;
         handlers_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite) begin
         case (csr_index)
            cefq_pkg::REG_BYPASS:   bypass_ff   <= csr_pwdata[0];
            cefq_pkg::REG_HANDLERS: handlers_ff <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         cefq_pkg::REG_BYPASS:   csr_prdata = {31'd0, bypass_ff};
         cefq_pkg::REG_HANDLERS: csr_prdata = {31'd0, handlers_ff};
         default:                csr_prdata = 32'd0;
      endcase
   end

   // The pending stage waits for the ring read; it drains whenever the
   // output register is free, so a new transfer can enter every cycle while that holds.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = pend_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   cefq_ctrl #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (req_action),
      .event_code (req_event_code),
      .bypass     (bypass_ff),
      .handlers   (handlers_ff),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .info       (info)
   );

   cefq_ring #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_ring (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (req_event_code),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_event (rd_event)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (accept) begin
            pend_valid_ff <= 1'b1;
         end else if (out_free) begin
            pend_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= pend_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_info_ff <= info;
      end
      if (out_free && pend_valid_ff) begin
         rsp_status_ff            <= pend_info_ff.status;
         rsp_popped_event_ff      <= pend_info_ff.pop_ok ? rd_event : cefq_pkg::EV_NONE;
         rsp_present_event_ff     <= pend_info_ff.present;
         rsp_prior_event_ff       <= pend_info_ff.prior;
         rsp_charger_online_ff    <= pend_info_ff.online;
         rsp_wireless_to_wired_ff <= pend_info_ff.wireless_to_wired;
         rsp_queue_count_ff       <= pend_info_ff.count;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_status            = rsp_status_ff;
   assign rsp_popped_event      = rsp_popped_event_ff;
   assign rsp_present_event     = rsp_present_event_ff;
   assign rsp_prior_event       = rsp_prior_event_ff;
   assign rsp_charger_online    = rsp_charger_online_ff;
   assign rsp_wireless_to_wired = rsp_wireless_to_wired_ff;
   assign rsp_queue_count       = rsp_queue_count_ff;

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for charger_event_filter_coalescing_queue.
// Holds its own predictor of the admission filter and event ring, drives the
// block through cefq_pkg codes and checks every response transfer in order.
`timescale 1ns / 100ps

module tb;

   localparam int          RING_SLOTS     = cefq_pkg::QUEUE_DEPTH;
   localparam logic [1:0]  ACT_UNUSED     = 2'd3;
   localparam int          SETTLE_CYCLES  = 4;
   localparam int          LONG_HOLD      = 300;
   localparam int          WATCHDOG_LIMIT = 3000;

   // Row is the new event, column the present one.
   localparam bit ADMIT_GRID [6][6] = '{
      '{0, 1, 0, 1, 1, 1},
      '{1, 0, 0, 0, 0, 0},
      '{0, 1, 0, 1, 1, 1},
      '{0, 0, 1, 0, 1, 1},
      '{0, 1, 1, 1, 0, 1},
      '{0, 0, 1, 1, 1, 0}
   };

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] popped;
      logic [2:0] present;
      logic [2:0] prior;
      logic       online;
      logic       wireless_to_wired;
      logic [3:0] count;
   } charger_result_type;

   class charger_scoreboard_type;
      bit                 bypass;
      bit                 handlers;
      logic [2:0]         present;
      logic [2:0]         prior;
      bit                 online;
      logic [2:0]         ring [RING_SLOTS];
      int                 wr;
      int                 rd;
      int                 merge_slot;
      bit                 merging;
      charger_result_type expected_results[$];
      int                 errors;
      int                 checked;
      int                 status_seen[7];

      function new();
         bypass = 0;
         handlers = 0;
         present = cefq_pkg::EV_NONE;
         prior = cefq_pkg::EV_NONE;
         online = 0;
         foreach (ring[i]) ring[i] = 3'd0;
         wr = 0;
         rd = 0;
         merge_slot = 0;
         merging = 0;
         errors = 0;
         checked = 0;
         foreach (status_seen[i]) status_seen[i] = 0;
      endfunction

      function void write_config(logic idx, bit value);
         if (idx == cefq_pkg::REG_BYPASS) begin
            bypass = value;
         end else begin
            handlers = value;
         end
      endfunction

      function int next_slot(int p);
         return (p + 1) % RING_SLOTS;
      endfunction

      function bit admits(logic [2:0] code);
         if (code >= cefq_pkg::EV_NONE) return 0;
         if (present >= cefq_pkg::EV_NONE) return 1;
         return ADMIT_GRID[code][present];
      endfunction

      // Returns 0 when the ring has no free slot.
      function bit ring_put(logic [2:0] code);
         if (next_slot(wr) == rd) return 0;
         if (merging) begin
            if (merge_slot == wr) wr = next_slot(wr);
            // The ring drained under the merge slot: start over on a fresh one.
            if (wr == rd) begin
               merge_slot = next_slot(merge_slot);
               wr = next_slot(wr);
               merging = 0;
            end
            ring[merge_slot] = code;
         end else begin
            ring[wr] = code;
            wr = next_slot(wr);
         end
         return 1;
      endfunction

      function logic [2:0] post_event(logic [2:0] code);
         logic [2:0] st;
         if (bypass || !handlers) return cefq_pkg::ST_IGNORED;
         if (!admits(code)) return cefq_pkg::ST_REJECTED;
         online = (code == cefq_pkg::EV_START_SINK) || (code == cefq_pkg::EV_START_WIRELESS);
         prior = present;
         present = code;
         st = ring_put(code) ? cefq_pkg::ST_QUEUED : cefq_pkg::ST_FULL;
         if ((code == cefq_pkg::EV_STOP_SINK || code == cefq_pkg::EV_STOP_SOURCE ||
              code == cefq_pkg::EV_STOP_WIRELESS) && !merging) begin
            merging = 1;
            merge_slot = wr;
         end
         return st;
      endfunction

      function void note_request(logic [1:0] act, logic [2:0] code);
         charger_result_type r;
         r.popped = cefq_pkg::EV_NONE;
         case (act)
            cefq_pkg::ACT_POST: begin
               r.status = post_event(code);
            end
            cefq_pkg::ACT_POP: begin
               if (wr == rd) begin
                  r.status = cefq_pkg::ST_EMPTY;
               end else begin
                  r.popped = ring[rd];
                  rd = next_slot(rd);
                  r.status = cefq_pkg::ST_POPPED;
               end
            end
            cefq_pkg::ACT_DRAIN: begin
               merging = 0;
               merge_slot = 0;
               r.status = cefq_pkg::ST_CLEARED;
            end
            default: begin
               r.status = cefq_pkg::ST_IGNORED;
            end
         endcase
         r.present = present;
         r.prior = prior;
         r.online = online;
         r.wireless_to_wired = (prior == cefq_pkg::EV_START_WIRELESS) &&
                               (present == cefq_pkg::EV_START_SINK);
         r.count = 4'((wr + RING_SLOTS - rd) % RING_SLOTS);
         expected_results.push_back(r);
      endfunction

      function void compare(string name, logic [3:0] want_v, logic [3:0] got_v);
         if (got_v !== want_v) begin
            $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
            errors++;
         end
      endfunction

      function void check_response(charger_result_type got);
         charger_result_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: response transfer with nothing expected, status actual %0d",
                     $time, got.status);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         checked++;
         status_seen[want.status]++;
         compare("status", want.status, got.status);
         compare("popped_event", want.popped, got.popped);
         compare("present_event", want.present, got.present);
         compare("prior_event", want.prior, got.prior);
         compare("charger_online", want.online, got.online);
         compare("wireless_to_wired", want.wireless_to_wired, got.wireless_to_wired);
         compare("queue_count", want.count, got.count);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_action;
   logic [2:0]  req_event_code;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [2:0]  rsp_status;
   logic [2:0]  rsp_popped_event;
   logic [2:0]  rsp_present_event;
   logic [2:0]  rsp_prior_event;
   logic        rsp_charger_online;
   logic        rsp_wireless_to_wired;
   logic [3:0]  rsp_queue_count;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   charger_scoreboard_type predictor = new();
   bit hold_request;
   int hold_count;
   int idle_cycles;
   int requests_sent;
   int settings_used;

   charger_event_filter_coalescing_queue i_dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_action            (req_action),
      .req_event_code        (req_event_code),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_popped_event      (rsp_popped_event),
      .rsp_present_event     (rsp_present_event),
      .rsp_prior_event       (rsp_prior_event),
      .rsp_charger_online    (rsp_charger_online),
      .rsp_wireless_to_wired (rsp_wireless_to_wired),
      .rsp_queue_count       (rsp_queue_count),
      .csr_psel              (csr_psel),
      .csr_penable           (csr_penable),
      .csr_pwrite            (csr_pwrite),
      .csr_paddr             (csr_paddr),
      .csr_pwdata            (csr_pwdata),
      .csr_prdata            (csr_prdata),
      .csr_pready            (csr_pready)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response checking.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         predictor.check_response(charger_result_type'{rsp_status, rsp_popped_event,
            rsp_present_event, rsp_prior_event, rsp_charger_online,
            rsp_wireless_to_wired, rsp_queue_count});
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   // Receiver pacing: random stall runs, free stretches, and a long hold on request.
   initial begin : rsp_pacing
      int run_left;
      run_left = 0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 0;
            hold_count++;
            rsp_stall <= 1'b1;
            run_left = LONG_HOLD;
         end else if (run_left > 0) begin
            run_left--;
         end else if ($urandom_range(0, 99) < 60) begin
            rsp_stall <= 1'b0;
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 4);
         end else begin
            rsp_stall <= 1'b1;
            run_left = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 30)
                                                    : $urandom_range(0, 3);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(input logic [1:0] act, input logic [2:0] code,
                               input bit gaps_on);
      int gap;
      req_valid <= 1'b1;
      req_action <= act;
      req_event_code <= code;
      do @(posedge clock); while (req_stall);
      predictor.note_request(act, code);
      requests_sent++;
      gap = gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Waits until the block is idle so that a register can be written.
   task automatic settle();
      req_valid <= 1'b0;
      while (predictor.expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic idx, input bit value);
      logic [31:0] data;
      data = $urandom;
      data[0] = value;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      predictor.write_config(idx, value);
      @(posedge clock);
   endtask

   task automatic configure(input bit bypass_v, input bit handlers_v);
      settle();
      write_register(cefq_pkg::REG_BYPASS, bypass_v);
      write_register(cefq_pkg::REG_HANDLERS, handlers_v);
      settings_used++;
   endtask

   // Posts mostly carry events that the table admits from the present event, the rest noise.
   task automatic pick_request(input int pop_pct, input int drain_pct,
                               output logic [1:0] act, output logic [2:0] code);
      int         r;
      logic [2:0] options[$];
      r = $urandom_range(0, 99);
      code = 3'($urandom_range(0, 7));
      if (r < pop_pct) begin
         act = cefq_pkg::ACT_POP;
      end else if (r < pop_pct + drain_pct) begin
         act = cefq_pkg::ACT_DRAIN;
      end else if (r < pop_pct + drain_pct + 2) begin
         act = ACT_UNUSED;
      end else begin
         act = cefq_pkg::ACT_POST;
         if ($urandom_range(0, 99) < 80) begin
            for (int c = 0; c < 6; c++) begin
               if (predictor.admits(3'(c))) options.push_back(3'(c));
            end
            code = options[$urandom_range(0, options.size() - 1)];
         end
      end
   endtask

   task automatic run_phase(input bit bypass_v, input bit handlers_v, input int items,
                            input int pop_pct, input int drain_pct, input bit gaps_on,
                            input bit long_hold);
      logic [1:0] act;
      logic [2:0] code;
      configure(bypass_v, handlers_v);
      if (long_hold) hold_request = 1;
      repeat (items) begin
         pick_request(pop_pct, drain_pct, act, code);
         send_request(act, code, gaps_on);
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_action = cefq_pkg::ACT_POST;
      req_event_code = cefq_pkg::EV_START_SINK;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = 3'd0;
      csr_pwdata = 32'd0;
      hold_request = 0;
      hold_count = 0;
      idle_cycles = 0;
      requests_sent = 0;
      settings_used = 1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // No handlers after reset, so the post is ignored.
      send_request(cefq_pkg::ACT_POST, cefq_pkg::EV_START_SINK, 1);
      configure(0, 1);
      send_request(cefq_pkg::ACT_POP, cefq_pkg::EV_NONE, 1);
      send_request(cefq_pkg::ACT_POST, 3'd7, 1);
      send_request(cefq_pkg::ACT_POST, cefq_pkg::EV_NONE, 1);
      // Nothing present yet: any valid event gets in.
      send_request(cefq_pkg::ACT_POST, cefq_pkg::EV_START_WIRELESS, 1);
      send_request(cefq_pkg::ACT_POST, cefq_pkg::EV_START_SINK, 1);
      send_request(cefq_pkg::ACT_POST, cefq_pkg::EV_START_SINK, 1);
      // A stop starts coalescing; the next two posts share one slot.
      send_request(cefq_pkg::ACT_POST, cefq_pkg::EV_STOP_SINK, 1);
      send_request(cefq_pkg::ACT_POST, cefq_pkg::EV_START_SOURCE, 1);
      send_request(cefq_pkg::ACT_POST, cefq_pkg::EV_STOP_SOURCE, 1);
      repeat (5) send_request(cefq_pkg::ACT_POP, 3'($urandom_range(0, 7)), 1);
      // Coalescing with the ring drained moves on to a fresh slot.
      send_request(cefq_pkg::ACT_POST, cefq_pkg::EV_START_WIRELESS, 1);
      send_request(ACT_UNUSED, 3'd7, 1);
      send_request(cefq_pkg::ACT_DRAIN, 3'($urandom_range(0, 7)), 1);
      send_request(cefq_pkg::ACT_POST, cefq_pkg::EV_STOP_WIRELESS, 1);
      send_request(cefq_pkg::ACT_POST, cefq_pkg::EV_START_SOURCE, 1);
      send_request(cefq_pkg::ACT_POP, cefq_pkg::EV_STOP_WIRELESS, 0);
      send_request(cefq_pkg::ACT_POP, cefq_pkg::EV_START_SINK, 0);

      run_phase(0, 1, 400, 30, 8, 1, 0);
      run_phase(1, 1, 60, 30, 8, 1, 0);
      // Few pops: the ring fills up while the receiver holds off once.
      run_phase(0, 1, 400, 8, 15, 0, 1);
      run_phase(0, 0, 60, 30, 8, 1, 0);
      run_phase(1, 0, 40, 30, 8, 1, 0);
      run_phase(0, 1, 700, 35, 6, 1, 0);

      settle();
      repeat (8) @(posedge clock);
      $display("summary: %0d requests, %0d register settings, %0d checked, %0d long hold",
               requests_sent, settings_used, predictor.checked, hold_count);
      $display("summary: queued %0d full %0d rejected %0d ignored %0d",
               predictor.status_seen[cefq_pkg::ST_QUEUED],
               predictor.status_seen[cefq_pkg::ST_FULL],
               predictor.status_seen[cefq_pkg::ST_REJECTED],
               predictor.status_seen[cefq_pkg::ST_IGNORED]);
      $display("summary: popped %0d empty %0d cleared %0d",
               predictor.status_seen[cefq_pkg::ST_POPPED],
               predictor.status_seen[cefq_pkg::ST_EMPTY],
               predictor.status_seen[cefq_pkg::ST_CLEARED]);
      if (predictor.errors == 0 && predictor.expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

[filelist.f]
src/cefq_pkg.sv
src/cefq_ring.sv
src/cefq_ctrl.sv
src/charger_event_filter_coalescing_queue.sv
tb/sv/tb.sv
